// ===== hdl/epsilon_packing_novelty_table_core_defines.svh =====
// Assertion macros for the epsilon packing novelty table core.
// Depends on nothing; included by the top level.
`ifndef EPSILON_PACKING_NOVELTY_TABLE_CORE_DEFINES_SVH
`define EPSILON_PACKING_NOVELTY_TABLE_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define ENT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal is one-cycle wide: it never stays high on consecutive edges.
`define ENT_PULSE(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) sig |=> !sig) else $error(msg);
`endif

// ===== hdl/ent_pkg.sv =====
// Package for the epsilon packing novelty table core: payload types, codes, constants.
// No dependencies.
package ent_pkg;
  localparam int MaxEntries = 256;
  localparam int Dimension  = 4;

  localparam logic [1:0] OpObserve = 2'd0;
  localparam logic [1:0] OpQuery   = 2'd1;
  localparam logic [1:0] OpClear   = 2'd2;
  localparam logic [1:0] OpNop     = 2'd3;

  localparam logic [1:0] MetL1   = 2'd0;
  localparam logic [1:0] MetL2   = 2'd1;
  localparam logic [1:0] MetLinf = 2'd2;
  localparam logic [1:0] MetCos  = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  localparam logic [1:0] RegLow  = 2'd0;
  localparam logic [1:0] RegHigh = 2'd1;
  localparam logic [1:0] RegEps  = 2'd2;
  localparam logic [1:0] RegMet  = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] coord_3;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_0;
  } in_t;

  typedef struct packed {
    logic        novel;
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic [8:0]  peak_entries;
    logic [31:0] observation_total;
    logic [31:0] novel_total;
    logic [31:0] generation_count;
  } out_t;

  // Signed 16-bit lane of a packed point.
  function automatic logic signed [15:0] lane(input logic [63:0] p, input int d);
    lane = p[d*16 +: 16];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

// ===== hdl/epsilon_packing_novelty_table_core.sv =====
// Epsilon packing novelty table core: takes one transaction while idle and scans the table
// one entry per cycle through a registered-read memory; after the scan the verdict is taken
// in SDone and the strobe is raised from SOut. Clear, out-of-range and the unused code go
// straight to SOut. A new transaction is taken only once the core is idle again; no stalls.
// Reset is asynchronous active low and restores counters and registers; the memory is not
// cleared, only entries below the fill count are read. Uses ent_pkg, ent_store, ent_dist.
`include "epsilon_packing_novelty_table_core_defines.svh"
module epsilon_packing_novelty_table_core #(
  parameter int MaxEntries = ent_pkg::MaxEntries,
  parameter int Dimension  = ent_pkg::Dimension
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ent_pkg::in_t    item_i,
  output logic            done_o,
  output ent_pkg::out_t   result_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [63:0]     cfg_data_i
);
  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CW = $clog2(MaxEntries + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SDone = 3'd2;
  localparam logic [2:0] SOut  = 3'd3;

  // Configuration registers.
  logic [63:0] low_q, high_q;
  logic [31:0] eps_q;
  logic [1:0]  met_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 64'h8000_8000_8000_8000;
      high_q <= 64'h7FFF_7FFF_7FFF_7FFF;
      eps_q  <= '0;
      met_q  <= ent_pkg::MetLinf;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ent_pkg::RegLow:  low_q  <= cfg_data_i;
        ent_pkg::RegHigh: high_q <= cfg_data_i;
        ent_pkg::RegEps:  eps_q  <= cfg_data_i[31:0];
        default:          met_q  <= cfg_data_i[1:0];
      endcase
    end
  end

  // State and statistics.
  logic [2:0]    st_q;
  logic [CW-1:0] cnt_q, peak_q;
  logic [31:0]   obs_q, nov_q, gen_q;
  logic [63:0]   pt_q;
  logic [1:0]    op_q;
  logic [CW-1:0] rd_q;      // next address to issue
  logic [CW-1:0] left_q;    // distances still to fold in
  logic [1:0]    pipe_q;    // valid shift: memory read data, lane terms
  logic signed [47:0] best_q;
  logic          have_q;
  ent_pkg::out_t res_q;
  logic          done_q;

  logic [63:0] pt_in;
  assign pt_in = {item_i.coord_3, item_i.coord_2, item_i.coord_1, item_i.coord_0};

  logic in_box;
  always_comb begin
    in_box = 1'b1;
    for (int d = 0; d < Dimension; d++) begin
      if (ent_pkg::lane(pt_in, d) < ent_pkg::lane(low_q, d) ||
          ent_pkg::lane(pt_in, d) > ent_pkg::lane(high_q, d)) in_box = 1'b0;
    end
  end

  // Only observe and query test the point against the box.
  logic range_err;
  assign range_err = ((item_i.operation == ent_pkg::OpObserve) ||
                      (item_i.operation == ent_pkg::OpQuery)) && !in_box;

  logic [63:0] rdata;
  logic        we;
  ent_store #(.Depth(MaxEntries), .AW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(pt_q),
    .raddr_i(rd_q[AW-1:0]), .rdata_o(rdata)
  );

  logic signed [47:0] rep_gap;
  ent_dist #(.Dim(Dimension)) u_dist (
    .clk_i, .metric_i(met_q), .pt_i(pt_q), .rep_i(rdata), .dist_o(rep_gap)
  );

  // Final verdict from the running minimum.
  logic nv;
  logic [63:0] e2;
  assign e2 = 64'(eps_q) * 64'(eps_q);
  always_comb begin
    if (!have_q) nv = 1'b1;
    else if (met_q == ent_pkg::MetL2) nv = 64'(best_q) > e2;
    else nv = best_q > 48'sd0 + $signed({16'd0, eps_q});
  end

  logic full;
  assign full = (cnt_q >= CW'(MaxEntries));
  assign we = (st_q == SDone) && (op_q == ent_pkg::OpObserve) && nv && !full;

  assign busy = (st_q != SIdle);
  logic acc;
  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; peak_q <= '0;
      obs_q <= '0; nov_q <= '0; gen_q <= '0;
      rd_q <= '0; left_q <= '0; pipe_q <= '0; have_q <= 1'b0;
      done_q <= 1'b0; op_q <= ent_pkg::OpObserve;
      pt_q <= '0; res_q <= '0; best_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        SIdle: if (acc) begin
          pt_q <= pt_in;
          op_q <= item_i.operation;
          res_q.novel <= 1'b0;
          res_q.status <= range_err ? ent_pkg::StRange : ent_pkg::StOk;
          rd_q <= '0; left_q <= cnt_q; pipe_q <= '0; have_q <= 1'b0;
          if (item_i.operation == ent_pkg::OpClear) begin
            cnt_q <= '0; peak_q <= '0; obs_q <= '0; nov_q <= '0;
            gen_q <= ent_pkg::sat_inc(gen_q);
            st_q <= SOut;
          end else if (item_i.operation == ent_pkg::OpNop) begin
            st_q <= SOut;
          end else if (!in_box) begin
            st_q <= SOut;
          end else begin
            st_q <= (cnt_q == '0) ? SDone : SScan;
          end
        end
        SScan: begin
          pipe_q <= {pipe_q[0], (rd_q < cnt_q)};
          if (rd_q < cnt_q) rd_q <= rd_q + 1'b1;
          if (pipe_q[1]) begin
            if (!have_q || rep_gap < best_q) best_q <= rep_gap;
            have_q <= 1'b1;
            left_q <= left_q - 1'b1;
            if (left_q == CW'(1)) st_q <= SDone;
          end
        end
        SDone: begin
          res_q.novel <= nv;
          if (op_q == ent_pkg::OpObserve) begin
            if (nv && full) begin
              res_q.status <= ent_pkg::StFull;
            end else begin
              if (nv) begin
                cnt_q <= cnt_q + 1'b1;
                if (cnt_q + 1'b1 > peak_q) peak_q <= cnt_q + 1'b1;
                nov_q <= ent_pkg::sat_inc(nov_q);
              end
              obs_q <= ent_pkg::sat_inc(obs_q);
              gen_q <= ent_pkg::sat_inc(gen_q);
            end
          end
          st_q <= SOut;
        end
        default: begin
          done_q <= 1'b1;
          st_q <= SIdle;
        end
      endcase
    end
  end

  assign done_o = done_q;
  always_comb begin
    result_o = res_q;
    result_o.entry_count = 9'(cnt_q);
    result_o.peak_entries = 9'(peak_q);
    result_o.observation_total = obs_q;
    result_o.novel_total = nov_q;
    result_o.generation_count = gen_q;
  end

  `ENT_PULSE(a_done_pulse, clk_i, rst_ni, done_o, "result strobe longer than one cycle")
  `ENT_ASSERT(a_peak, clk_i, rst_ni, peak_q >= cnt_q, "peak below entry count")
  `ENT_ASSERT(a_cap, clk_i, rst_ni, cnt_q <= CW'(MaxEntries), "entry count over capacity")
  `ENT_ASSERT(a_busy_done, clk_i, rst_ni, done_o |-> !busy, "strobe while busy")
endmodule

// ===== hdl/ent_store.sv =====
// Representative memory: one write port, one registered read port.
// Depends on ent_pkg for nothing but is instantiated by the core top level.
module ent_store #(
  parameter int Depth = 256,
  parameter int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  logic [63:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== hdl/ent_dist.sv =====
// Registered distance unit: one representative per cycle, four lanes in parallel.
// Depends on ent_pkg for the metric codes and lane helper.
module ent_dist #(
  parameter int Dim = ent_pkg::Dimension
) (
  input  logic               clk_i,
  input  logic [1:0]         metric_i,
  input  logic [63:0]        pt_i,
  input  logic [63:0]        rep_i,
  output logic signed [47:0] dist_o
);
  // Stage 1: per-lane term; stage 2: combine.
  logic signed [47:0] term_q [4];
  logic signed [47:0] term_d [4];

  always_comb begin
    logic signed [16:0] x, y, diff, mag;
    for (int d = 0; d < 4; d++) begin
      x = 17'(ent_pkg::lane(pt_i, d));
      y = 17'(ent_pkg::lane(rep_i, d));
      diff = x - y;
      mag = diff[16] ? -diff : diff;
      if (d >= Dim) begin
        term_d[d] = '0;
      end else begin
        case (metric_i) inside
          ent_pkg::MetL1, ent_pkg::MetLinf: term_d[d] = 48'(mag);
          ent_pkg::MetL2: term_d[d] = 48'(diff) * 48'(diff);
          default:        term_d[d] = 48'(x) * 48'(y);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 4; d++) term_q[d] <= term_d[d];
  end

  always_comb begin
    logic signed [47:0] m01, m23;
    m01 = (term_q[0] > term_q[1]) ? term_q[0] : term_q[1];
    m23 = (term_q[2] > term_q[3]) ? term_q[2] : term_q[3];
    case (metric_i)
      ent_pkg::MetLinf: dist_o = (m01 > m23) ? m01 : m23;
      ent_pkg::MetCos:  dist_o = 48'sd65536 - (term_q[0] + term_q[1] + term_q[2] + term_q[3]);
      default:          dist_o = term_q[0] + term_q[1] + term_q[2] + term_q[3];
    endcase
  end
endmodule
